@@ rtl/ole_pkg.sv @@
// shared types, constants and ring address helper for the ordered list engine
package ole_pkg;

    localparam int DEPTH      = 256;
    localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int DATA_W     = 32;
    localparam int KIND_W     = 3;
    localparam int POS_W      = 9;
    localparam int STATUS_W   = 2;
    localparam int OUT_CNT_W  = 9;
    localparam int CMP_W      = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam int S_TDATA_W  = ((DATA_W + POS_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((DATA_W + OUT_CNT_W + 7) / 8) * 8;

    typedef enum logic [KIND_W-1:0] {
        K_INS_FRONT = 3'd0,
        K_INS_REAR  = 3'd1,
        K_DEL_FRONT = 3'd2,
        K_DEL_REAR  = 3'd3,
        K_INS_POS   = 3'd4,
        K_REVERSE   = 3'd5
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_BAD_POS = 2'd3
    } status_t;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        logic [DATA_W-1:0] wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } ram_req_t;

    typedef struct packed {
        status_t              status;
        logic [DATA_W-1:0]    removed;
        logic [OUT_CNT_W-1:0] count;
    } res_t;

    // physical slot of logical index k (0 <= k <= DEPTH) in the ring
    function automatic logic [ADDR_W-1:0] slot_of(
        input logic [ADDR_W-1:0] front,
        input logic              rev,
        input logic [CNT_W-1:0]  k
    );
        logic [CNT_W-1:0]  off;
        logic [ADDR_W:0]   sum;
        off = (k >= CNT_W'(DEPTH)) ? k - CNT_W'(DEPTH) : k;
        if (rev)
        begin
            sum = {1'b0, front} + (ADDR_W+1)'(DEPTH) - (ADDR_W+1)'(off);
        end
        else
        begin
            sum = {1'b0, front} + (ADDR_W+1)'(off);
        end
        if (sum >= (ADDR_W+1)'(DEPTH))
        begin
            sum = sum - (ADDR_W+1)'(DEPTH);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

@@ rtl/ole_ram.sv @@
// generic single write port, single read port ram with registered read
module ole_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/ole_core.sv @@
// list sequencer: ring pointers, count and read-modify-write steps on the store
module ole_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ole_pkg::KIND_W-1:0]    in_kind,
    input  logic signed [ole_pkg::DATA_W-1:0] in_value,
    input  logic [ole_pkg::POS_W-1:0]     in_pos,
    output ole_pkg::ram_req_t             ram_req,
    input  logic [ole_pkg::DATA_W-1:0]    ram_rdata,
    output logic                          res_valid,
    input  logic                          res_ready,
    output ole_pkg::res_t                 res
);
    import ole_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_PUT,
        S_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   front_reg, front_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                rev_reg, rev_next;
    logic [CNT_W-1:0]    j_reg, j_next;
    logic [CNT_W-1:0]    pos_reg, pos_next;
    logic [DATA_W-1:0]   val_reg, val_next;
    status_t             status_reg, status_next;
    logic [DATA_W-1:0]   removed_reg, removed_next;

    logic                accept;
    logic                full;
    logic                empty;
    logic [CMP_W-1:0]    pos_ext;
    logic [CMP_W-1:0]    cnt_ext;
    logic [CNT_W-1:0]    j_dec;

    assign accept  = in_valid && (state_reg == S_IDLE);
    assign full    = (count_reg >= CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign pos_ext = CMP_W'(in_pos);
    assign cnt_ext = CMP_W'(count_reg);
    assign j_dec   = j_reg - CNT_W'(1);

    always_comb
    begin
        state_next   = state_reg;
        front_next   = front_reg;
        count_next   = count_reg;
        rev_next     = rev_reg;
        j_next       = j_reg;
        pos_next     = pos_reg;
        val_next     = val_reg;
        status_next  = status_reg;
        removed_next = removed_reg;
        ram_req      = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next  = ST_OK;
                    removed_next = '0;
                    state_next   = S_DONE;
                    unique case (kind_t'(in_kind))
                        K_INS_FRONT:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                front_next    = slot_of(front_reg, !rev_reg, CNT_W'(1));
                                ram_req.we    = 1'b1;
                                ram_req.waddr = front_next;
                                ram_req.wdata = in_value;
                                count_next    = count_reg + CNT_W'(1);
                            end
                        end
                        K_INS_REAR:
                        begin
                            if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                ram_req.we    = 1'b1;
                                ram_req.waddr = slot_of(front_reg, rev_reg, count_reg);
                                ram_req.wdata = in_value;
                                count_next    = count_reg + CNT_W'(1);
                            end
                        end
                        K_DEL_FRONT:
                        begin
                            if (empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                ram_req.re    = 1'b1;
                                ram_req.raddr = front_reg;
                                front_next    = slot_of(front_reg, rev_reg, CNT_W'(1));
                                count_next    = count_reg - CNT_W'(1);
                                state_next    = S_READ;
                            end
                        end
                        K_DEL_REAR:
                        begin
                            if (empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                ram_req.re    = 1'b1;
                                ram_req.raddr = slot_of(front_reg, rev_reg,
                                                        count_reg - CNT_W'(1));
                                count_next    = count_reg - CNT_W'(1);
                                state_next    = S_READ;
                            end
                        end
                        K_INS_POS:
                        begin
                            if ((pos_ext == '0) || (pos_ext > cnt_ext + CMP_W'(1)))
                            begin
                                status_next = ST_BAD_POS;
                            end
                            else if (full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                pos_next   = CNT_W'(in_pos);
                                val_next   = in_value;
                                j_next     = count_reg;
                                state_next = (cnt_ext >= pos_ext) ? S_SHIFT_RD : S_PUT;
                            end
                        end
                        K_REVERSE:
                        begin
                            if (!empty)
                            begin
                                front_next = slot_of(front_reg, rev_reg,
                                                     count_reg - CNT_W'(1));
                            end
                            rev_next = !rev_reg;
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                removed_next = ram_rdata;
                state_next   = S_DONE;
            end
            S_SHIFT_RD:
            begin
                ram_req.re    = 1'b1;
                ram_req.raddr = slot_of(front_reg, rev_reg, j_dec);
                state_next    = S_SHIFT_WR;
            end
            S_SHIFT_WR:
            begin
                // element j-1 moves up into slot j
                ram_req.we    = 1'b1;
                ram_req.waddr = slot_of(front_reg, rev_reg, j_reg);
                ram_req.wdata = ram_rdata;
                j_next        = j_dec;
                state_next    = (j_dec >= pos_reg) ? S_SHIFT_RD : S_PUT;
            end
            S_PUT:
            begin
                ram_req.we    = 1'b1;
                ram_req.waddr = slot_of(front_reg, rev_reg, pos_reg - CNT_W'(1));
                ram_req.wdata = val_reg;
                count_next    = count_reg + CNT_W'(1);
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            front_reg  <= '0;
            count_reg  <= '0;
            rev_reg    <= 1'b0;
            status_reg <= ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            front_reg  <= front_next;
            count_reg  <= count_next;
            rev_reg    <= rev_next;
            status_reg <= status_next;
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg       <= j_next;
        pos_reg     <= pos_next;
        val_reg     <= val_next;
        removed_reg <= removed_next;
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign res_valid   = (state_reg == S_DONE);
    assign res.status  = status_reg;
    assign res.removed = removed_reg;
    assign res.count   = OUT_CNT_W'(count_reg);

endmodule

@@ rtl/ordered_list_engine_top.sv @@
// top level of the ordered list engine: stream ports, output register, store ram
//
// bounded ordered list of signed 32-bit values, up to DEPTH (256) entries,
// kept in a ring buffer ram with a front pointer and a direction flag
// slave stream: one transfer is one operation; s_tuser carries the kind,
//   s_tdata carries the value and the 1-based insert position
// master stream: one transfer per operation with status in m_tuser and the
//   removed value and new count in m_tdata
// steps from input transfer to m_tvalid, through the sequencer states:
//   end inserts, reverse, rejected or unused kinds: done, output register
//   deletes: ram read issued on acceptance, read, done, output register
//   positional insert: a shift read and a shift write state for each entry
//   shifted up, one ram read and one ram write on the single port pair,
//   then put, done, output register; done waits for the register to free
// the next input transfer is taken once the sequencer is back to idle
// a finished result sits in the output register; the sequencer can take
// and work the next operation while that result waits, and holds its own
// result until the output register frees up
// reset clears pointers, count, direction and all valid flags; the store
// content itself is not cleared and no unwritten entry is ever read
module ordered_list_engine_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [2:0] kind
    input  logic [ole_pkg::KIND_W-1:0]      s_tuser,
    // [31:0] value, [40:32] position, rest zero
    input  logic [ole_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [1:0] status
    output logic [ole_pkg::STATUS_W-1:0]    m_tuser,
    // [31:0] removed_value, [40:32] count, rest zero
    output logic [ole_pkg::M_TDATA_W-1:0]   m_tdata
);
    import ole_pkg::*;

    ram_req_t            ram_req;
    logic [DATA_W-1:0]   ram_rdata;
    logic                res_valid;
    logic                res_ready;
    res_t                res;

    logic                out_valid_reg;
    res_t                out_res_reg;

    ole_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_kind   (s_tuser),
        .in_value  (s_tdata[DATA_W-1:0]),
        .in_pos    (s_tdata[DATA_W+POS_W-1:DATA_W]),
        .ram_req   (ram_req),
        .ram_rdata (ram_rdata),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // element store
    ole_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    // output register frees when empty or when the current transfer completes
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.status;
    assign m_tdata  = M_TDATA_W'({out_res_reg.count, out_res_reg.removed});

    // sequencer never takes input while holding an undelivered result
    a_ready_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !res_valid)
        else $error("input ready while a result is pending");

    // an accepted input is never followed directly by another
    a_accept_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("back to back input transfer");

    // an empty delete reports nothing removed and a zero count on an empty list
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == ST_EMPTY)) |->
        ((m_tdata[DATA_W-1:0] == '0) && (m_tdata[DATA_W+OUT_CNT_W-1:DATA_W] == '0)))
        else $error("empty status with nonzero removed value or count");

    // a full status always comes with a full count
    a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == ST_FULL)) |->
        (m_tdata[DATA_W+OUT_CNT_W-1:DATA_W] == OUT_CNT_W'(DEPTH)))
        else $error("full status with count below depth");

    // a waiting result holds while stalled
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("output changed while stalled");

endmodule

@@ tb/tb_ordered_list_engine_top.sv @@
`timescale 1ns / 100ps
// self-checking testbench for the ordered list engine: shadow list predictor and result scoreboard
module tb_ordered_list_engine_top;
    import ole_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 5;
    // longest quiet stretch of a correct run is a positional insert at the
    // front of a nearly full list or the receiver hold-off below; the
    // watchdog allows several times either
    localparam int STALL_LIMIT  = 5000;
    localparam int DRAIN_CYCLES = 20;
    localparam int GAP_PCT      = 33;
    localparam int HOLD_CYCLES  = 300;

    // kinds with no operation behind them, the block must answer ok and change nothing
    localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // [2:0] kind
    logic [KIND_W-1:0]    s_tuser  = '0;
    // [31:0] value, [40:32] position, rest zero
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // [1:0] status
    logic [STATUS_W-1:0]  m_tuser;
    // [31:0] removed_value, [40:32] count, rest zero
    logic [M_TDATA_W-1:0] m_tdata;

    // logical contents of the list, front at index 0
    logic [DATA_W-1:0] shadow_list[$];
    // results predicted for accepted operations, oldest first
    res_t              pending_results[$];
    int                mismatch_count = 0;
    int                quiet_cycles   = 0;

    // traffic shaping knobs, written only by the test sequence
    bit                tx_steady      = 1'b0;
    bit                rx_steady      = 1'b0;
    int                hold_requests  = 0;

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    ordered_list_engine_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tuser  (m_tuser),
        .m_tdata  (m_tdata)
    );

    // applies one accepted operation to the shadow list and queues its result
    task automatic apply_list_op(
        input logic [KIND_W-1:0] k,
        input logic [DATA_W-1:0] v,
        input logic [POS_W-1:0]  p
    );
        res_t              r;
        logic [DATA_W-1:0] tmp;
        int                n;
        r.status  = ST_OK;
        r.removed = '0;
        n         = shadow_list.size();
        case (k)
            K_INS_FRONT:
            begin
                if (n >= DEPTH)
                    r.status = ST_FULL;
                else
                    shadow_list.push_front(v);
            end
            K_INS_REAR:
            begin
                if (n >= DEPTH)
                    r.status = ST_FULL;
                else
                    shadow_list.push_back(v);
            end
            K_DEL_FRONT:
            begin
                if (n == 0)
                    r.status = ST_EMPTY;
                else
                    r.removed = shadow_list.pop_front();
            end
            K_DEL_REAR:
            begin
                if (n == 0)
                    r.status = ST_EMPTY;
                else
                    r.removed = shadow_list.pop_back();
            end
            K_INS_POS:
            begin
                // range is checked before fullness
                if (p == '0 || int'(p) > n + 1)
                    r.status = ST_BAD_POS;
                else if (n >= DEPTH)
                    r.status = ST_FULL;
                else if (int'(p) == n + 1)
                    shadow_list.push_back(v);
                else
                    shadow_list.insert(int'(p) - 1, v);
            end
            K_REVERSE:
            begin
                for (int i = 0; i < n / 2; i++)
                begin
                    tmp                    = shadow_list[i];
                    shadow_list[i]         = shadow_list[n - 1 - i];
                    shadow_list[n - 1 - i] = tmp;
                end
            end
            default:
            begin
            end
        endcase
        r.count = OUT_CNT_W'(shadow_list.size());
        pending_results.push_back(r);
    endtask

    // monitor: both streams sampled at the rising edge, before the block updates
    always @(posedge clk)
    begin : result_check
        res_t want;
        if (m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result transfer with no operation outstanding");
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (m_tuser !== want.status)
                begin
                    $error("status: expected %0d, actual %0d", want.status, m_tuser);
                    mismatch_count++;
                end
                if (m_tdata[DATA_W-1:0] !== want.removed)
                begin
                    $error("removed_value: expected %0d, actual %0d",
                           $signed(want.removed), $signed(m_tdata[DATA_W-1:0]));
                    mismatch_count++;
                end
                if (m_tdata[DATA_W +: OUT_CNT_W] !== want.count)
                begin
                    $error("count: expected %0d, actual %0d",
                           want.count, m_tdata[DATA_W +: OUT_CNT_W]);
                    mismatch_count++;
                end
            end
        end
        if (s_tvalid && s_tready)
            apply_list_op(s_tuser, s_tdata[DATA_W-1:0], s_tdata[DATA_W +: POS_W]);
    end

    // watchdog: ends the run when neither stream moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver: random back-pressure, a steady mode, and long hold-offs on request
    always @(negedge clk)
    begin : result_sink
        int hold_seen;
        int hold_left;
        if (hold_requests != hold_seen)
        begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left--;
        end
        else if (rx_steady)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(99) >= GAP_PCT);
    end

    // offers one operation, returns at the falling edge after its transfer
    task automatic send_op(
        input logic [KIND_W-1:0] k,
        input logic [DATA_W-1:0] v,
        input logic [POS_W-1:0]  p
    );
        if (!tx_steady && $urandom_range(99) < GAP_PCT)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= S_TDATA_W'({p, v});
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // random element, with the signed extremes and all-zero / all-one mixed in
    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // random operations steering the list toward a fill level; positions
    // are mostly legal, the rest zero or past the end
    task automatic random_ops(input int n_ops, input int fill_goal);
        int                n;
        int                r;
        logic [KIND_W-1:0] k;
        logic [POS_W-1:0]  p;
        for (int i = 0; i < n_ops; i++)
        begin
            n = shadow_list.size();
            r = $urandom_range(99);
            p = POS_W'($urandom_range(511));
            if (r < 8)
                k = K_REVERSE;
            else if (r < 11)
                k = ($urandom_range(1) == 1) ? KIND_SPARE_A : KIND_SPARE_B;
            else if ($urandom_range(99) < ((n < fill_goal) ? 70 : 30))
            begin
                case ($urandom_range(2))
                    0:       k = K_INS_FRONT;
                    1:       k = K_INS_REAR;
                    default:
                    begin
                        k = K_INS_POS;
                        if ($urandom_range(99) < 85)
                            p = POS_W'($urandom_range(n + 1, 1));
                        else if ($urandom_range(1) == 0)
                            p = '0;
                        else
                            p = POS_W'($urandom_range(511, n + 2));
                    end
                endcase
            end
            else
                k = ($urandom_range(1) == 1) ? K_DEL_FRONT : K_DEL_REAR;
            send_op(k, pick_value(), p);
        end
    endtask

    // deletes and reverse on an empty list, bad positions, unused kinds
    task automatic test_empty_list();
        send_op(K_DEL_FRONT, pick_value(), 9'd1);
        send_op(K_DEL_REAR, pick_value(), 9'd1);
        send_op(K_REVERSE, pick_value(), 9'd0);
        send_op(K_INS_POS, pick_value(), 9'd0);
        send_op(K_INS_POS, pick_value(), 9'd2);
        send_op(KIND_SPARE_A, $urandom, 9'h1ff);
        send_op(KIND_SPARE_B, $urandom, 9'h0aa);
    endtask

    // every operation on a short list, left in reversed direction by the test above
    task automatic test_basic_ops();
        send_op(K_INS_POS, 32'h8000_0000, 9'd1);
        send_op(K_INS_FRONT, 32'h7fff_ffff, 9'd0);
        send_op(K_INS_REAR, 32'h0000_0000, 9'd0);
        send_op(K_INS_REAR, 32'hffff_ffff, 9'd0);
        send_op(K_INS_POS, 32'h1234_5678, 9'h1ff);
        send_op(K_INS_POS, 32'h5555_aaaa, 9'd3);
        // count + 1 is still a legal position: append at the rear
        send_op(K_INS_POS, 32'haaaa_5555, 9'd6);
        send_op(K_REVERSE, pick_value(), 9'd0);
        send_op(K_DEL_FRONT, pick_value(), 9'd0);
        send_op(K_DEL_REAR, pick_value(), 9'd0);
        send_op(K_INS_FRONT, 32'hdead_beef, 9'd0);
        send_op(K_REVERSE, pick_value(), 9'd0);
        send_op(K_DEL_FRONT, pick_value(), 9'd0);
        send_op(K_DEL_REAR, pick_value(), 9'd0);
    endtask

    // fill to capacity, hit every full case, then drain past empty
    task automatic test_full_list();
        while (shadow_list.size() < DEPTH)
            send_op(($urandom_range(1) == 1) ? K_INS_REAR : K_INS_FRONT, pick_value(), 9'd0);
        send_op(K_INS_FRONT, pick_value(), 9'd0);
        send_op(K_INS_REAR, pick_value(), 9'd0);
        // legal positions on a full list report full, not a bad position
        send_op(K_INS_POS, pick_value(), 9'd1);
        send_op(K_INS_POS, pick_value(), 9'(DEPTH + 1));
        send_op(K_INS_POS, pick_value(), 9'(DEPTH + 2));
        send_op(K_INS_POS, pick_value(), 9'h1ff);
        send_op(K_REVERSE, pick_value(), 9'd0);
        while (shadow_list.size() > 0)
            send_op(($urandom_range(1) == 1) ? K_DEL_REAR : K_DEL_FRONT, pick_value(), 9'd0);
        send_op(K_DEL_FRONT, pick_value(), 9'd0);
    endtask

    // receiver holds off while the sender keeps offering, so the block backs up
    task automatic test_output_backpressure();
        tx_steady = 1'b1;
        hold_requests++;
        random_ops(12, 8);
        tx_steady = 1'b0;
    endtask

    // no idle cycles on either side
    task automatic test_back_to_back();
        tx_steady = 1'b1;
        rx_steady = 1'b1;
        random_ops(60, 30);
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // random traffic at a range of fill levels
    task automatic test_random_mix();
        random_ops(50, 6);
        random_ops(40, 60);
        random_ops(30, DEPTH - 1);
        random_ops(20, 2);
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_list();
        test_basic_ops();
        test_full_list();
        test_output_backpressure();
        test_back_to_back();
        test_random_mix();

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        // stray results after the last one would show up here
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/ole_pkg.sv
rtl/ole_ram.sv
rtl/ole_core.sv
rtl/ordered_list_engine_top.sv
tb/tb_ordered_list_engine_top.sv
